@@ design/greedy_delta_r_matcher_macros.svh @@
// ----------------------------------------------------------------------------
// Greedy deltaR matcher assertion macros
// Shorthand for the concurrent checks at the end of the top level; they expect
// clk and arst_n in scope.
// ----------------------------------------------------------------------------
`ifndef GREEDY_DELTA_R_MATCHER_MACROS_SVH
`define GREEDY_DELTA_R_MATCHER_MACROS_SVH

// consequent holds in the same cycle as the antecedent
`define GDRM_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// consequent holds in the cycle after the antecedent
`define GDRM_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ design/gdrm_pkg.sv @@
// ----------------------------------------------------------------------------
// Greedy deltaR matcher package
// Shared widths, constants and the command and result types.
// ----------------------------------------------------------------------------
package gdrm_pkg;

	// default store depths
	localparam int DEF_MAX_SRC = 16;
	localparam int DEF_MAX_DST = 16;

	// stream widths (fields padded to whole bytes)
	localparam int S_TDATA_W = 32;
	localparam int M_TDATA_W = 16;

	// input field widths
	localparam int ETA_W = 14;
	localparam int PHI_W = 13;
	localparam int PT_W  = ETA_W + PHI_W;

	// result index fields are four bits, so at most this many results per event
	localparam int OUT_LIMIT = 16;
	localparam int RIDX_W    = 4;

	// command fields sized for the largest store depth (64)
	localparam int CMD_ADDR_W = 6;
	localparam int CMD_CNT_W  = 7;

	// distance arithmetic: deta 15 bits, wrapped dphi 15 bits, sum of squares 29 bits
	localparam int DIFF_W = 15;
	localparam int SQ_W   = 28;
	localparam int DIST_W = 29;
	localparam logic signed [DIFF_W-1:0] PI_Q     = 15'sd3217;
	localparam logic signed [DIFF_W-1:0] NEG_PI_Q = -15'sd3217;
	localparam logic signed [DIFF_W-1:0] TWO_PI_Q = 15'sd6434;

	// what the front end made of one input beat
	typedef enum logic [1:0] {
		CMD_SRC,
		CMD_DST,
		CMD_DROP
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t               kind;
		logic [CMD_ADDR_W-1:0]   addr;
		logic [ETA_W-1:0]        eta;
		logic [PHI_W-1:0]        phi;
		logic                    last;
		logic [CMD_CNT_W-1:0]    src_cnt;   // counts after this beat, used on last
		logic [CMD_CNT_W-1:0]    dst_cnt;
		logic                    overflow;
	} cmd_t;

	typedef struct packed {
		logic                    end_of_run;
		logic                    overflow;
		logic [RIDX_W-1:0]       dst_index;
		logic                    matched;
		logic [RIDX_W-1:0]       src_index;
	} res_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_INIT,
		ST_SCAN,
		ST_DRAIN,
		ST_EMIT_RD,
		ST_EMIT_LD,
		ST_DONE
	} back_state_t;

endpackage

@@ design/gdrm_ram.sv @@
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module gdrm_ram #(
	parameter int W     = 8,
	parameter int DEPTH = 16,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [W-1:0]  wdata,
	input  logic [AW-1:0] raddr,
	output logic [W-1:0]  rdata
);

	logic [W-1:0] mem [DEPTH];

	// write, then registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

@@ design/gdrm_front.sv @@
// ----------------------------------------------------------------------------
// Greedy deltaR matcher front end
// Accepts point beats, counts them per event and classifies each as a
// source store, a destination store or a drop.
// ----------------------------------------------------------------------------
module gdrm_front #(
	parameter int MAX_SRC = gdrm_pkg::DEF_MAX_SRC,
	parameter int MAX_DST = gdrm_pkg::DEF_MAX_DST
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [gdrm_pkg::S_TDATA_W-1:0]  s_tdata,
	input  logic                            s_tuser,
	input  logic                            s_tlast,
	output logic                            cmd_valid,
	input  logic                            cmd_ready,
	output gdrm_pkg::cmd_t                  cmd
);
	import gdrm_pkg::*;

	localparam int SCNT_W = $clog2(MAX_SRC + 1);
	localparam int DCNT_W = $clog2(MAX_DST + 1);

	logic [SCNT_W-1:0] src_cnt_q;
	logic [DCNT_W-1:0] dst_cnt_q;
	logic              ovf_q;
	logic              beat;
	logic              src_full;
	logic              dst_full;
	logic              store_src;
	logic              store_dst;
	logic              drop;
	logic [SCNT_W-1:0] src_n;
	logic [DCNT_W-1:0] dst_n;

	assign beat      = s_tvalid && cmd_ready;
	assign s_tready  = cmd_ready;
	assign cmd_valid = s_tvalid;

	// classification against the current fill
	assign src_full  = (src_cnt_q == SCNT_W'(MAX_SRC));
	assign dst_full  = (dst_cnt_q == DCNT_W'(MAX_DST));
	assign store_src = !s_tuser && !src_full;
	assign store_dst = s_tuser && !dst_full;
	assign drop      = !store_src && !store_dst;
	assign src_n     = store_src ? src_cnt_q + SCNT_W'(1) : src_cnt_q;
	assign dst_n     = store_dst ? dst_cnt_q + DCNT_W'(1) : dst_cnt_q;

	// command for the back end
	always_comb begin
		cmd.kind     = drop ? CMD_DROP : (s_tuser ? CMD_DST : CMD_SRC);
		cmd.addr     = s_tuser ? CMD_ADDR_W'(dst_cnt_q) : CMD_ADDR_W'(src_cnt_q);
		cmd.eta      = s_tdata[ETA_W-1:0];
		cmd.phi      = s_tdata[PT_W-1:ETA_W];
		cmd.last     = s_tlast;
		cmd.src_cnt  = CMD_CNT_W'(src_n);
		cmd.dst_cnt  = CMD_CNT_W'(dst_n);
		cmd.overflow = ovf_q || drop;
	end

	// per-event fill counts, cleared by the beat that ends the event
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_cnt_q <= '0;
			dst_cnt_q <= '0;
			ovf_q     <= 1'b0;
		end else if (beat) begin
			if (s_tlast) begin
				src_cnt_q <= '0;
				dst_cnt_q <= '0;
				ovf_q     <= 1'b0;
			end else begin
				src_cnt_q <= src_n;
				dst_cnt_q <= dst_n;
				ovf_q     <= ovf_q || drop;
			end
		end
	end

endmodule

@@ design/gdrm_queue.sv @@
// ----------------------------------------------------------------------------
// Greedy deltaR matcher command queue
// Two-entry queue between front end and back end.
// ----------------------------------------------------------------------------
module gdrm_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  gdrm_pkg::cmd_t in_data,
	output logic           out_valid,
	input  logic           out_ready,
	output gdrm_pkg::cmd_t out_data
);
	import gdrm_pkg::*;

	localparam int DEPTH = 2;

	cmd_t       mem_q [DEPTH];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;
	logic       push;
	logic       pop;

	assign in_ready  = (cnt_q != 2'(DEPTH));
	assign out_valid = (cnt_q != 2'd0);
	assign out_data  = mem_q[rd_ptr_q];
	assign push      = in_valid && in_ready;
	assign pop       = out_valid && out_ready;

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= in_data;
		end
	end

	// pointers and fill
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

endmodule

@@ design/gdrm_back.sv @@
// ----------------------------------------------------------------------------
// Greedy deltaR matcher back end
// Stores points, runs the greedy matching rounds through a distance
// pipeline and emits one result per source point, at most sixteen.
// ----------------------------------------------------------------------------
module gdrm_back #(
	parameter int MAX_SRC = gdrm_pkg::DEF_MAX_SRC,
	parameter int MAX_DST = gdrm_pkg::DEF_MAX_DST
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cmd_valid,
	output logic           cmd_ready,
	input  gdrm_pkg::cmd_t cmd,
	output logic           res_valid,
	input  logic           res_ready,
	output gdrm_pkg::res_t res
);
	import gdrm_pkg::*;

	localparam int SIDX_W  = (MAX_SRC > 1) ? $clog2(MAX_SRC) : 1;
	localparam int DIDX_W  = (MAX_DST > 1) ? $clog2(MAX_DST) : 1;
	localparam int SCNT_W  = $clog2(MAX_SRC + 1);
	localparam int DCNT_W  = $clog2(MAX_DST + 1);
	localparam int OUT_MAX = (MAX_SRC < OUT_LIMIT) ? MAX_SRC : OUT_LIMIT;

	// lowest set bit at or above a start index
	function automatic logic [SIDX_W:0] pick_src(input logic [MAX_SRC-1:0] m,
			input logic [SIDX_W:0] from);
		logic              found;
		logic [SIDX_W-1:0] idx;
		found = 1'b0;
		idx   = '0;
		for (int k = MAX_SRC - 1; k >= 0; k--) begin
			if (m[k] && (k >= int'(from))) begin
				found = 1'b1;
				idx   = SIDX_W'(k);
			end
		end
		return {found, idx};
	endfunction

	function automatic logic [DIDX_W:0] pick_dst(input logic [MAX_DST-1:0] m,
			input logic [DIDX_W:0] from);
		logic              found;
		logic [DIDX_W-1:0] idx;
		found = 1'b0;
		idx   = '0;
		for (int k = MAX_DST - 1; k >= 0; k--) begin
			if (m[k] && (k >= int'(from))) begin
				found = 1'b1;
				idx   = DIDX_W'(k);
			end
		end
		return {found, idx};
	endfunction

	// phi difference folded back by one turn, twice
	function automatic logic signed [DIFF_W-1:0] wrap_phi(input logic signed [DIFF_W-1:0] x);
		logic signed [DIFF_W-1:0] y;
		y = x;
		for (int k = 0; k < 2; k++) begin
			if (y > PI_Q) begin
				y = y - TWO_PI_Q;
			end else if (y < NEG_PI_Q) begin
				y = y + TWO_PI_Q;
			end
		end
		return y;
	endfunction

	back_state_t state_q, state_d;

	// event registers
	logic [SCNT_W-1:0]  sc_q;
	logic [DCNT_W-1:0]  dc_q;
	logic               ovf_q;
	logic [MAX_SRC-1:0] src_taken_q;
	logic [MAX_DST-1:0] dst_taken_q;
	logic [MAX_SRC-1:0] src_av;
	logic [MAX_DST-1:0] dst_av;

	// scan position
	logic [SIDX_W-1:0]  i_q;
	logic [DIDX_W-1:0]  j_q;
	logic [SIDX_W:0]    first_s, nxt_s;
	logic [DIDX_W:0]    first_d, nxt_d;

	// distance pipeline
	logic                     v_s1, v_s2, v_s3;
	logic [SIDX_W-1:0]        i_s1, i_s2, i_s3;
	logic [DIDX_W-1:0]        j_s1, j_s2, j_s3;
	logic signed [DIFF_W-1:0] deta_s2, dphi_s2;
	logic [SQ_W-1:0]          sqe_s3, sqp_s3;
	logic [PT_W-1:0]          src_rd, dst_rd;
	logic signed [ETA_W-1:0]  eta_s, eta_d;
	logic signed [PHI_W-1:0]  phi_s, phi_d;
	logic signed [DIFF_W-1:0] deta, dphi_raw;
	logic signed [2*DIFF_W-1:0] sqe_full, sqp_full;
	logic [DIST_W-1:0]        pair_d2;

	// running best pair of the round
	logic                     found_q;
	logic [DIST_W-1:0]        best_q;
	logic [SIDX_W-1:0]        bi_q;
	logic [DIDX_W-1:0]        bj_q;

	// result side
	logic [SCNT_W-1:0]        o_idx_q;
	logic [SCNT_W-1:0]        n_out;
	logic                     o_last;
	logic [DIDX_W-1:0]        mram_rd;
	logic [SCNT_W+RIDX_W-1:0] oext;
	logic [DIDX_W+RIDX_W-1:0] dext;
	logic                     res_valid_q;
	res_t                     res_q;

	// controls
	logic pop, start_scan, issue, pipe_empty, commit, load_out, clear_ev;
	logic src_we, dst_we;

	assign pop        = cmd_valid && cmd_ready;
	assign src_we     = pop && (cmd.kind == CMD_SRC);
	assign dst_we     = pop && (cmd.kind == CMD_DST);
	assign pipe_empty = !v_s1 && !v_s2 && !v_s3;

	// untaken points inside the loaded counts
	always_comb begin
		for (int k = 0; k < MAX_SRC; k++) begin
			src_av[k] = (k < int'(sc_q)) && !src_taken_q[k];
		end
		for (int k = 0; k < MAX_DST; k++) begin
			dst_av[k] = (k < int'(dc_q)) && !dst_taken_q[k];
		end
	end

	assign first_s = pick_src(src_av, '0);
	assign first_d = pick_dst(dst_av, '0);
	assign nxt_s   = pick_src(src_av, {1'b0, i_q} + (SIDX_W+1)'(1));
	assign nxt_d   = pick_dst(dst_av, {1'b0, j_q} + (DIDX_W+1)'(1));

	// number of results and end of run
	assign n_out  = (sc_q > SCNT_W'(OUT_MAX)) ? SCNT_W'(OUT_MAX) : sc_q;
	assign o_last = (({1'b0, o_idx_q} + (SCNT_W+1)'(1)) == {1'b0, n_out});

	// point and match stores
	gdrm_ram #(.W(PT_W), .DEPTH(MAX_SRC)) u_src_ram (
		.clk   (clk),
		.we    (src_we),
		.waddr (cmd.addr[SIDX_W-1:0]),
		.wdata ({cmd.phi, cmd.eta}),
		.raddr (i_q),
		.rdata (src_rd)
	);

	gdrm_ram #(.W(PT_W), .DEPTH(MAX_DST)) u_dst_ram (
		.clk   (clk),
		.we    (dst_we),
		.waddr (cmd.addr[DIDX_W-1:0]),
		.wdata ({cmd.phi, cmd.eta}),
		.raddr (j_q),
		.rdata (dst_rd)
	);

	gdrm_ram #(.W(DIDX_W), .DEPTH(MAX_SRC)) u_match_ram (
		.clk   (clk),
		.we    (commit),
		.waddr (bi_q),
		.wdata (bj_q),
		.raddr (o_idx_q[SIDX_W-1:0]),
		.rdata (mram_rd)
	);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (cmd_valid && cmd.last) begin
					state_d = ST_INIT;
				end
			end
			ST_INIT: begin
				priority if (first_s[SIDX_W] && first_d[DIDX_W]) begin
					state_d = ST_SCAN;
				end else if (n_out == '0) begin
					state_d = ST_DONE;
				end else begin
					state_d = ST_EMIT_RD;
				end
			end
			ST_SCAN: begin
				if (!nxt_d[DIDX_W] && !nxt_s[SIDX_W]) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (pipe_empty) begin
					state_d = ST_INIT;
				end
			end
			ST_EMIT_RD: begin
				state_d = ST_EMIT_LD;
			end
			ST_EMIT_LD: begin
				if (load_out) begin
					state_d = o_last ? ST_DONE : ST_EMIT_RD;
				end
			end
			ST_DONE: begin
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// state outputs
	always_comb begin
		cmd_ready  = 1'b0;
		start_scan = 1'b0;
		issue      = 1'b0;
		commit     = 1'b0;
		load_out   = 1'b0;
		clear_ev   = 1'b0;
		unique case (state_q)
			ST_IDLE:    cmd_ready  = 1'b1;
			ST_INIT:    start_scan = first_s[SIDX_W] && first_d[DIDX_W];
			ST_SCAN:    issue      = 1'b1;
			ST_DRAIN:   commit     = pipe_empty;
			ST_EMIT_RD: load_out   = 1'b0;
			ST_EMIT_LD: load_out   = !res_valid_q || res_ready;
			ST_DONE:    clear_ev   = 1'b1;
			default:    clear_ev   = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// event counts, taken bits, scan position and result index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sc_q        <= '0;
			dc_q        <= '0;
			ovf_q       <= 1'b0;
			src_taken_q <= '0;
			dst_taken_q <= '0;
			i_q         <= '0;
			j_q         <= '0;
			o_idx_q     <= '0;
		end else begin
			if (pop && cmd.last) begin
				sc_q  <= cmd.src_cnt[SCNT_W-1:0];
				dc_q  <= cmd.dst_cnt[DCNT_W-1:0];
				ovf_q <= cmd.overflow;
			end
			if (clear_ev) begin
				src_taken_q <= '0;
				dst_taken_q <= '0;
			end else if (commit) begin
				src_taken_q[bi_q] <= 1'b1;
				dst_taken_q[bj_q] <= 1'b1;
			end
			if (start_scan) begin
				i_q <= first_s[SIDX_W-1:0];
				j_q <= first_d[DIDX_W-1:0];
			end else if (issue) begin
				if (nxt_d[DIDX_W]) begin
					j_q <= nxt_d[DIDX_W-1:0];
				end else if (nxt_s[SIDX_W]) begin
					i_q <= nxt_s[SIDX_W-1:0];
					j_q <= first_d[DIDX_W-1:0];
				end
			end
			if (clear_ev) begin
				o_idx_q <= '0;
			end else if (load_out) begin
				o_idx_q <= o_idx_q + SCNT_W'(1);
			end
		end
	end

	// stage 1 data arrives from the stores; differences and phi wrap
	assign eta_s    = src_rd[ETA_W-1:0];
	assign phi_s    = src_rd[PT_W-1:ETA_W];
	assign eta_d    = dst_rd[ETA_W-1:0];
	assign phi_d    = dst_rd[PT_W-1:ETA_W];
	assign deta     = DIFF_W'(eta_s) - DIFF_W'(eta_d);
	assign dphi_raw = DIFF_W'(phi_s) - DIFF_W'(phi_d);

	// squares
	assign sqe_full = deta_s2 * deta_s2;
	assign sqp_full = dphi_s2 * dphi_s2;

	// sum for the compare
	assign pair_d2 = {1'b0, sqe_s3} + {1'b0, sqp_s3};

	// pipeline valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= issue;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	// pipeline payload
	always_ff @(posedge clk) begin
		i_s1    <= i_q;
		j_s1    <= j_q;
		i_s2    <= i_s1;
		j_s2    <= j_s1;
		deta_s2 <= deta;
		dphi_s2 <= wrap_phi(dphi_raw);
		i_s3    <= i_s2;
		j_s3    <= j_s2;
		sqe_s3  <= sqe_full[SQ_W-1:0];
		sqp_s3  <= sqp_full[SQ_W-1:0];
	end

	// best pair: strict less keeps the earliest pair in scan order
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q <= 1'b0;
		end else if (start_scan) begin
			found_q <= 1'b0;
		end else if (v_s3 && (!found_q || (pair_d2 < best_q))) begin
			found_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (v_s3 && (!found_q || (pair_d2 < best_q))) begin
			best_q <= pair_d2;
			bi_q   <= i_s3;
			bj_q   <= j_s3;
		end
	end

	// result register
	assign oext = {{RIDX_W{1'b0}}, o_idx_q};
	assign dext = {{RIDX_W{1'b0}}, mram_rd};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (load_out) begin
			res_valid_q <= 1'b1;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			res_q.src_index  <= oext[RIDX_W-1:0];
			res_q.matched    <= src_taken_q[o_idx_q[SIDX_W-1:0]];
			res_q.dst_index  <= src_taken_q[o_idx_q[SIDX_W-1:0]] ?
				dext[RIDX_W-1:0] : '0;
			res_q.overflow   <= ovf_q;
			res_q.end_of_run <= o_last;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

endmodule

@@ design/greedy_delta_r_matcher.sv @@
// ----------------------------------------------------------------------------
// Greedy deltaR matcher
// Collects source and destination (eta, phi) points per event and pairs them
// by greedy closest-first matching on deltaR squared.
// ----------------------------------------------------------------------------
// Points are loaded one beat per cycle while the command queue has room (tuser
// high for a destination); the beat with tlast ends the event. Matching then
// runs in rounds: a round scans every pair of untaken sources and destinations
// on the single distance pipeline, with set-up, drain and commit, and a round
// is run for every pair formed. Results follow, each by a match-store read and
// a load of the output register, one per source in load order, at most sixteen,
// the final one with tlast. Points past a full store are dropped and flagged as
// overflow. Loads of the next event are held in a two-beat queue while the
// current event is matched and emitted.
`include "greedy_delta_r_matcher_macros.svh"

module greedy_delta_r_matcher #(
	parameter int MAX_SRC = gdrm_pkg::DEF_MAX_SRC,
	parameter int MAX_DST = gdrm_pkg::DEF_MAX_DST
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// s_tdata: eta [13:0], phi [26:14], zero [31:27]; s_tuser: is_dst; s_tlast: last
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [gdrm_pkg::S_TDATA_W-1:0]  s_tdata,
	input  logic                            s_tuser,
	input  logic                            s_tlast,
	// m_tdata: src_index [3:0], matched [4], dst_index [8:5], overflow [9],
	// zero [15:10]; m_tlast: end_of_run
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [gdrm_pkg::M_TDATA_W-1:0]  m_tdata,
	output logic                            m_tlast
);
	import gdrm_pkg::*;

	localparam int RES_W = $bits(res_t);

	logic fq_valid, fq_ready;
	cmd_t fq_cmd;
	logic qb_valid, qb_ready;
	cmd_t qb_cmd;
	res_t res;
	logic [RES_W-1:0] res_bits;

	gdrm_front #(.MAX_SRC(MAX_SRC), .MAX_DST(MAX_DST)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.s_tlast   (s_tlast),
		.cmd_valid (fq_valid),
		.cmd_ready (fq_ready),
		.cmd       (fq_cmd)
	);

	gdrm_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (fq_valid),
		.in_ready  (fq_ready),
		.in_data   (fq_cmd),
		.out_valid (qb_valid),
		.out_ready (qb_ready),
		.out_data  (qb_cmd)
	);

	gdrm_back #(.MAX_SRC(MAX_SRC), .MAX_DST(MAX_DST)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (qb_valid),
		.cmd_ready (qb_ready),
		.cmd       (qb_cmd),
		.res_valid (m_tvalid),
		.res_ready (m_tready),
		.res       (res)
	);

	// result beat packing, end_of_run travels as tlast
	assign res_bits = res;
	assign m_tdata  = {{(M_TDATA_W - RES_W + 1){1'b0}}, res_bits[RES_W-2:0]};
	assign m_tlast  = res.end_of_run;

	// a beat straight after the end of a run opens the next run at source zero
	`GDRM_ASSERT_NEXT(a_run_restart, m_tvalid && m_tready && m_tlast,
		!m_tvalid || (m_tdata[3:0] == 4'd0),
		"run did not restart at source zero")

	// within a run source indexes step by one
	`GDRM_ASSERT_NEXT(a_idx_step, m_tvalid && m_tready && !m_tlast,
		!m_tvalid || (m_tdata[3:0] == $past(m_tdata[3:0]) + 4'd1),
		"source index did not advance by one")

	// overflow is an event property and holds across the run
	`GDRM_ASSERT_NEXT(a_ovf_run, m_tvalid && m_tready && !m_tlast,
		!m_tvalid || (m_tdata[9] == $past(m_tdata[9])),
		"overflow changed within a run")

	// an unmatched source reports destination zero
	`GDRM_ASSERT_SAME(a_unmatched_zero, m_tvalid && !m_tdata[4], m_tdata[8:5] == 4'd0,
		"unmatched result with nonzero destination index")

endmodule

@@ verif/greedy_delta_r_matcher_chk.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Greedy deltaR matcher checker
// Watches both stream channels and rebuilds each event from the accepted point
// beats. On tlast it pairs the points closest-first and queues one awaited
// result per source, at most sixteen. Each result beat is compared field by
// field with the oldest awaited result.
// ----------------------------------------------------------------------------
module greedy_delta_r_matcher_chk (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	input  logic                            s_tready,
	input  logic [gdrm_pkg::S_TDATA_W-1:0]  s_tdata,
	input  logic                            s_tuser,
	input  logic                            s_tlast,
	input  logic                            m_tvalid,
	input  logic                            m_tready,
	input  logic [gdrm_pkg::M_TDATA_W-1:0]  m_tdata,
	input  logic                            m_tlast,
	output int                              errors,
	output int                              pending,
	output int                              results_checked,
	output int                              pairs_seen
);

	localparam int NSRC     = gdrm_pkg::DEF_MAX_SRC;
	localparam int NDST     = gdrm_pkg::DEF_MAX_DST;
	localparam int ETA_W    = gdrm_pkg::ETA_W;
	localparam int PHI_W    = gdrm_pkg::PHI_W;
	localparam int RIDX_W   = gdrm_pkg::RIDX_W;
	localparam int HALF_TURN = gdrm_pkg::PI_Q;
	localparam int FULL_TURN = gdrm_pkg::TWO_PI_Q;

	// result beat layout, lowest bit up
	localparam int MATCHED_BIT = RIDX_W;
	localparam int DST_LSB     = RIDX_W + 1;
	localparam int OVF_BIT     = 2 * RIDX_W + 1;
	localparam int PAD_LSB     = 2 * RIDX_W + 2;

	// points of the event being collected
	logic signed [ETA_W-1:0] src_eta [NSRC];
	logic signed [PHI_W-1:0] src_phi [NSRC];
	logic signed [ETA_W-1:0] dst_eta [NDST];
	logic signed [PHI_W-1:0] dst_phi [NDST];
	int n_src       = 0;
	int n_dst       = 0;
	bit dropped     = 1'b0;

	int err_count   = 0;
	int res_count   = 0;
	int pair_count  = 0;

	gdrm_pkg::res_t awaited_results[$];

	// deltaR squared in Q20, phi difference wrapped by at most two turns
	function automatic longint delta_r_sq(int si, int di);
		int de;
		int dp;
		de = int'(src_eta[si]) - int'(dst_eta[di]);
		dp = int'(src_phi[si]) - int'(dst_phi[di]);
		repeat (2) begin
			if (dp > HALF_TURN)
				dp -= FULL_TURN;
			else if (dp < -HALF_TURN)
				dp += FULL_TURN;
		end
		return longint'(de) * de + longint'(dp) * dp;
	endfunction

	// closest-first pairing of the collected event, then queue its results
	function automatic void greedy_pair_event();
		bit             s_used [NSRC];
		bit             d_used [NDST];
		bit             paired [NSRC];
		int             partner [NSRC];
		int             rounds;
		int             bi;
		int             bj;
		int             i;
		int             j;
		int             k;
		bit             found;
		longint         best;
		longint         d;
		gdrm_pkg::res_t r;
		for (i = 0; i < NSRC; i++) begin
			s_used[i]  = 1'b0;
			paired[i]  = 1'b0;
			partner[i] = 0;
		end
		for (j = 0; j < NDST; j++)
			d_used[j] = 1'b0;
		rounds = (n_src < n_dst) ? n_src : n_dst;
		for (k = 0; k < rounds; k++) begin
			found = 1'b0;
			best  = 0;
			bi    = 0;
			bj    = 0;
			// strict compare keeps the lowest source, then destination, on ties
			for (i = 0; i < n_src; i++) begin
				if (!s_used[i]) begin
					for (j = 0; j < n_dst; j++) begin
						if (!d_used[j]) begin
							d = delta_r_sq(i, j);
							if (!found || d < best) begin
								found = 1'b1;
								best  = d;
								bi    = i;
								bj    = j;
							end
						end
					end
				end
			end
			if (found) begin
				s_used[bi]  = 1'b1;
				d_used[bj]  = 1'b1;
				paired[bi]  = 1'b1;
				partner[bi] = bj;
			end
		end
		for (i = 0; i < n_src && i < gdrm_pkg::OUT_LIMIT; i++) begin
			r.src_index  = i[RIDX_W-1:0];
			r.matched    = paired[i];
			r.dst_index  = paired[i] ? partner[i][RIDX_W-1:0] : '0;
			r.overflow   = dropped;
			r.end_of_run = (i + 1 == n_src) || (i + 1 == gdrm_pkg::OUT_LIMIT);
			awaited_results.insert(awaited_results.size(), r);
		end
		// event is consumed whether or not it produced results
		n_src   = 0;
		n_dst   = 0;
		dropped = 1'b0;
	endfunction

	function automatic void check_field(string name, int want, int got);
		if (want != got) begin
			$error("%s mismatch: expected %0d, actual %0d", name, want, got);
			err_count++;
		end
	endfunction

	// both channels sampled on the clock edge, inputs handled first
	always @(posedge clk) begin
		gdrm_pkg::res_t          want;
		logic signed [ETA_W-1:0] eta_in;
		logic signed [PHI_W-1:0] phi_in;
		if (arst_n) begin
			// point beat: store it, or drop it when that store is full
			if (s_tvalid && s_tready) begin
				eta_in = s_tdata[ETA_W-1:0];
				phi_in = s_tdata[ETA_W +: PHI_W];
				if (s_tuser) begin
					if (n_dst < NDST) begin
						dst_eta[n_dst] = eta_in;
						dst_phi[n_dst] = phi_in;
						n_dst++;
					end else
						dropped = 1'b1;
				end else begin
					if (n_src < NSRC) begin
						src_eta[n_src] = eta_in;
						src_phi[n_src] = phi_in;
						n_src++;
					end else
						dropped = 1'b1;
				end
				if (s_tlast)
					greedy_pair_event();
			end
			// result beat against the oldest awaited result
			if (m_tvalid && m_tready) begin
				if (awaited_results.size() == 0) begin
					$error("result beat with none awaited: tdata %h, tlast %b",
						m_tdata, m_tlast);
					err_count++;
				end else begin
					want = awaited_results.pop_front();
					check_field("src_index", want.src_index, m_tdata[RIDX_W-1:0]);
					check_field("matched", want.matched, m_tdata[MATCHED_BIT]);
					check_field("dst_index", want.dst_index, m_tdata[DST_LSB +: RIDX_W]);
					check_field("overflow", want.overflow, m_tdata[OVF_BIT]);
					check_field("end_of_run", want.end_of_run, m_tlast);
					check_field("tdata padding", 0,
						m_tdata[gdrm_pkg::M_TDATA_W-1:PAD_LSB]);
					res_count++;
					if (want.matched)
						pair_count++;
				end
			end
		end
		errors          <= err_count;
		pending         <= awaited_results.size();
		results_checked <= res_count;
		pairs_seen      <= pair_count;
	end

endmodule

@@ verif/greedy_delta_r_matcher_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Greedy deltaR matcher testbench
// Drives point beats into the matcher, a directed set first (field extremes,
// phi wrap and out-of-range phi, equal distances, an event with no sources,
// a full store with a dropped last point), then random events under four
// idling regimes. The checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module greedy_delta_r_matcher_tb;

	localparam int RANDOM_ITEMS = 140;
	localparam int LIMIT_CYCLES = 2000000;
	localparam int TAIL_CYCLES  = 200;

	logic                            clk      = 1'b0;
	logic                            arst_n   = 1'b0;
	logic                            s_tvalid = 1'b0;
	logic                            s_tready;
	logic [gdrm_pkg::S_TDATA_W-1:0]  s_tdata  = '0;
	logic                            s_tuser  = 1'b0;
	logic                            s_tlast  = 1'b0;
	logic                            m_tvalid;
	logic                            m_tready = 1'b0;
	logic [gdrm_pkg::M_TDATA_W-1:0]  m_tdata;
	logic                            m_tlast;

	int errors;
	int pending;
	int results_checked;
	int pairs_seen;

	int send_gap_pct   = 0;
	int recv_stall_pct = 0;
	int beats_sent     = 0;
	int events_sent    = 0;
	int cycle_count    = 0;

	always #2 clk = ~clk;

	greedy_delta_r_matcher u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	greedy_delta_r_matcher_chk u_chk (
		.clk             (clk),
		.arst_n          (arst_n),
		.s_tvalid        (s_tvalid),
		.s_tready        (s_tready),
		.s_tdata         (s_tdata),
		.s_tuser         (s_tuser),
		.s_tlast         (s_tlast),
		.m_tvalid        (m_tvalid),
		.m_tready        (m_tready),
		.m_tdata         (m_tdata),
		.m_tlast         (m_tlast),
		.errors          (errors),
		.pending         (pending),
		.results_checked (results_checked),
		.pairs_seen      (pairs_seen)
	);

	// receiver back-pressure
	always @(posedge clk) begin
		m_tready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= LIMIT_CYCLES) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// one point beat, with random idle cycles ahead of it
	task automatic send_point(input bit to_dst, input int eta, input int phi, input bit ends);
		logic [gdrm_pkg::S_TDATA_W-1:0] word;
		word = '0;
		word[gdrm_pkg::ETA_W-1:0]                = eta[gdrm_pkg::ETA_W-1:0];
		word[gdrm_pkg::ETA_W +: gdrm_pkg::PHI_W] = phi[gdrm_pkg::PHI_W-1:0];
		while (send_gap_pct != 0 && $urandom_range(99) < send_gap_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= word;
		s_tuser  <= to_dst;
		s_tlast  <= ends;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		beats_sent++;
	endtask

	// random event: sources and destinations interleaved, tlast on the final one
	task automatic play_event(input int n_s, input int n_d);
		bit coarse;
		bit to_dst;
		int eta;
		int phi;
		int left_s;
		int left_d;
		coarse = ($urandom_range(3) == 0);
		left_s = n_s;
		left_d = n_d;
		while (left_s + left_d > 0) begin
			to_dst = ($urandom_range(left_s + left_d - 1) < left_d);
			if (to_dst)
				left_d--;
			else
				left_s--;
			if (coarse) begin
				// few distinct positions so equal distances turn up
				eta = (int'($urandom_range(4)) - 2) * 512;
				phi = (int'($urandom_range(4)) - 2) * 1600;
			end else begin
				eta = int'($urandom_range(16383)) - 8192;
				if ($urandom_range(3) == 0)
					phi = int'($urandom_range(8191)) - 4096;
				else
					phi = int'($urandom_range(6434)) - 3217;
			end
			send_point(to_dst, eta, phi, (left_s + left_d) == 0);
		end
		events_sent++;
	endtask

	initial begin
		int k;
		int base;
		int sel;
		int quarter;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// field extremes, phi beyond pi, wrap across the pi boundary
		send_point(1'b0, -8192, -4096, 1'b0);
		send_point(1'b1, 8191, 4095, 1'b0);
		send_point(1'b0, 0, 3217, 1'b0);
		send_point(1'b1, 0, -3217, 1'b1);
		// equal distances: lower source index wins
		send_point(1'b0, 0, 0, 1'b0);
		send_point(1'b0, 0, 0, 1'b0);
		send_point(1'b1, 0, 0, 1'b1);
		// destination only: no results
		send_point(1'b1, 100, -100, 1'b1);
		// full source store, dropped point carries tlast
		for (k = 0; k < gdrm_pkg::DEF_MAX_SRC; k++)
			send_point(1'b0, k * 600 - 8000, (k % 4) * 1000 - 1500, 1'b0);
		send_point(1'b1, 0, 0, 1'b0);
		send_point(1'b0, 1234, 567, 1'b1);
		events_sent += 4;

		// random events, idling regime changes every quarter
		base = beats_sent;
		while (beats_sent - base < RANDOM_ITEMS) begin
			quarter = (beats_sent - base) * 4 / RANDOM_ITEMS;
			case (quarter)
				0: begin
					send_gap_pct   = 0;
					recv_stall_pct = 0;
				end
				1: begin
					send_gap_pct   = 46;
					recv_stall_pct = 0;
				end
				2: begin
					send_gap_pct   = 0;
					recv_stall_pct = 46;
				end
				default: begin
					send_gap_pct   = 15;
					recv_stall_pct = 15;
				end
			endcase
			sel = $urandom_range(19);
			if (sel == 0)
				play_event(0, $urandom_range(1, 4));
			else if (sel == 1)
				play_event($urandom_range(1, 4), 0);
			else if (sel <= 3)
				play_event($urandom_range(14, 19), $urandom_range(14, 19));
			else
				play_event($urandom_range(1, 6), $urandom_range(1, 6));
		end
		s_tvalid <= 1'b0;

		// drain: all awaited results, then a quiet tail for strays
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("Sent %0d point beats in %0d events under four idling regimes.",
			beats_sent, events_sent);
		$display("Checked %0d result beats, %0d of them paired.", results_checked, pairs_seen);
		if (errors == 0 && pending == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
